@@ src/assert_macros.svh @@
// assertion macros used by the top-level rtl file
// no dependencies; expects a clock named aclk and an active-low reset aresetn
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define CHECK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// implication checked on every rising edge outside reset
`define CHECK_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define CHECK_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ src/pble_pkg.sv @@
// types and constants of the positional byte list engine
// no dependencies; used by the cell, the pick logic and the top level
package pble_pkg;

    localparam int CAPACITY  = 64;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int MODE_W    = 3;
    localparam int POS_W     = 7;
    localparam int BYTE_W    = 8;
    localparam int FIDX_W    = 6;
    localparam int STAT_W    = 2;
    localparam int COUNT_W   = 7;
    localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 24;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_INSERT     = 3'd4,
        MODE_REMOVE     = 3'd5,
        MODE_READ       = 3'd6,
        MODE_FIND       = 3'd7
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_REM  = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [CMP_W-1:0]    pos;
        logic [CMP_W-1:0]    cnt;
        logic [BYTE_W-1:0]   key;
    } cell_ctrl_t;

endpackage

@@ src/pble_cell.sv @@
// one entry cell of the list row: holds a byte, shifts with its neighbors
// depends on pble_pkg
module pble_cell import pble_pkg::*; (
    input  logic                aclk,
    input  logic [CMP_W-1:0]    idx,
    input  cell_ctrl_t          ctrl,
    input  logic [BYTE_W-1:0]   left_data,
    input  logic [BYTE_W-1:0]   right_data,
    output logic [BYTE_W-1:0]   data,
    output logic                hit,
    output logic                match
);

    logic [BYTE_W-1:0] data_reg;
    logic [BYTE_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_INS: begin
                if (idx > ctrl.pos) begin
                    data_next = left_data;
                end else if (idx == ctrl.pos) begin
                    data_next = ctrl.key;
                end
            end
            CELL_REM: begin
                if (idx >= ctrl.pos) begin
                    data_next = right_data;
                end
            end
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign hit   = (idx == ctrl.pos);
    assign match = (idx < ctrl.cnt) && (data_reg == ctrl.key);

endmodule

@@ src/pble_pick.sv @@
// read selection and first-match encoder over the cell row
// depends on pble_pkg
module pble_pick import pble_pkg::*; (
    input  logic [BYTE_W-1:0]   cell_data [CAPACITY],
    input  logic [CAPACITY-1:0] hit,
    input  logic [CAPACITY-1:0] match,
    output logic [BYTE_W-1:0]   rd_data,
    output logic                found,
    output logic [IDX_W-1:0]    found_idx
);

    always_comb begin
        rd_data = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_data = rd_data | (cell_data[i] & {BYTE_W{hit[i]}});
        end
    end

    always_comb begin
        found_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (match[i]) begin
                found_idx = IDX_W'(i);
            end
        end
    end

    assign found = |match;

endmodule

@@ src/positional_byte_list_engine_core.sv @@
// top level of the positional byte list engine: control, cell row, result register
// depends on pble_pkg, pble_cell, pble_pick and assert_macros.svh
//
// channel  dir  fields (lsb first)
// s_       in   mode[2:0] position[9:3] data_in[17:10], zero pad to 24
// m_       out  data_out[7:0] found[8] found_index[14:9] status[16:15] count[23:17]
//
// one word per cycle while s_tready is high: each word is applied to the cell row in the cycle it is taken
// the result is registered at the edge that takes the word and is offered from the next cycle
// the row of cells shifts, reads and compares all entries in that one cycle
// s_tready drops only while a result waits and m_tready is low
// reset clears the entry count and the result valid flag; entries are not cleared
`include "assert_macros.svh"

module positional_byte_list_engine_core import pble_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // mode, position, data_in
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata    // data_out, found, found_index, status, count
);

    logic                   s_fire;
    mode_t                  mode;
    logic [POS_W-1:0]       pos;
    logic [BYTE_W-1:0]      din;
    logic [CMP_W-1:0]       cnt_ext;
    logic [CMP_W-1:0]       pos_ext;
    logic                   full;
    logic                   empty;

    cell_op_t               op;
    logic [CMP_W-1:0]       sp;
    status_t                st;
    logic                   grow;
    logic                   shrink;
    logic                   take;
    logic                   want_find;
    cell_ctrl_t             ctrl;

    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   out_valid_reg;
    logic [M_DATA_W-1:0]    out_data_reg;
    logic [M_DATA_W-1:0]    out_data_next;

    logic [BYTE_W-1:0]      cell_data [CAPACITY];
    logic [CAPACITY-1:0]    hit;
    logic [CAPACITY-1:0]    match;
    logic [BYTE_W-1:0]      rd_data;
    logic                   any_match;
    logic [IDX_W-1:0]       match_idx;

    logic [BYTE_W-1:0]      res_data;
    logic                   res_found;
    logic [FIDX_W-1:0]      res_fidx;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    assign mode    = mode_t'(s_tdata[MODE_W-1:0]);
    assign pos     = s_tdata[MODE_W +: POS_W];
    assign din     = s_tdata[MODE_W + POS_W +: BYTE_W];
    assign cnt_ext = CMP_W'(count_reg);
    assign pos_ext = CMP_W'(pos);
    assign full    = (cnt_ext == CMP_W'(CAPACITY));
    assign empty   = (count_reg == '0);

    // decode of one word against the current count
    always_comb begin
        op        = CELL_HOLD;
        sp        = pos_ext;
        st        = ST_OK;
        grow      = 1'b0;
        shrink    = 1'b0;
        take      = 1'b0;
        want_find = 1'b0;
        case (mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                sp = (mode == MODE_PUSH_FRONT) ? '0 : cnt_ext;
                if (full) begin
                    st = ST_FULL;
                end else begin
                    op   = CELL_INS;
                    grow = 1'b1;
                end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
                sp = (mode == MODE_POP_FRONT) ? '0 : cnt_ext - CMP_W'(1);
                if (empty) begin
                    st = ST_EMPTY;
                end else begin
                    op     = CELL_REM;
                    shrink = 1'b1;
                    take   = 1'b1;
                end
            end
            MODE_INSERT: begin
                if (full) begin
                    st = ST_FULL;
                end else if (pos_ext > cnt_ext) begin
                    st = ST_RANGE;
                end else begin
                    op   = CELL_INS;
                    grow = 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (empty) begin
                    st = ST_EMPTY;
                end else if (pos_ext >= cnt_ext) begin
                    st = ST_RANGE;
                end else begin
                    op     = CELL_REM;
                    shrink = 1'b1;
                    take   = 1'b1;
                end
            end
            MODE_READ: begin
                if (pos_ext >= cnt_ext) begin
                    st = ST_RANGE;
                end else begin
                    take = 1'b1;
                end
            end
            MODE_FIND: begin
                want_find = 1'b1;
            end
            default: begin
                op = CELL_HOLD;
            end
        endcase
    end

    assign ctrl.op  = s_fire ? op : CELL_HOLD;
    assign ctrl.pos = sp;
    assign ctrl.cnt = cnt_ext;
    assign ctrl.key = din;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [BYTE_W-1:0] left_d;
            logic [BYTE_W-1:0] right_d;
            if (gi == 0) begin : g_first
                assign left_d = din;
            end else begin : g_mid_l
                assign left_d = cell_data[gi - 1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign right_d = cell_data[gi];
            end else begin : g_mid_r
                assign right_d = cell_data[gi + 1];
            end
            pble_cell u_cell (
                .aclk       (aclk),
                .idx        (CMP_W'(gi)),
                .ctrl       (ctrl),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[gi]),
                .hit        (hit[gi]),
                .match      (match[gi])
            );
        end
    endgenerate

    pble_pick u_pick (
        .cell_data (cell_data),
        .hit       (hit),
        .match     (match),
        .rd_data   (rd_data),
        .found     (any_match),
        .found_idx (match_idx)
    );

    always_comb begin
        count_next = count_reg;
        if (s_fire) begin
            count_next = count_reg + CNT_W'(grow) - CNT_W'(shrink);
        end
    end

    assign res_data  = take ? rd_data : '0;
    assign res_found = want_find && any_match;
    assign res_fidx  = res_found ? FIDX_W'(match_idx) : '0;

    always_comb begin
        out_data_next = '0;
        out_data_next[BYTE_W-1:0]                   = res_data;
        out_data_next[BYTE_W]                       = res_found;
        out_data_next[BYTE_W + 1 +: FIDX_W]         = res_fidx;
        out_data_next[BYTE_W + 1 + FIDX_W +: STAT_W] = st;
        out_data_next[BYTE_W + 1 + FIDX_W + STAT_W +: COUNT_W] = COUNT_W'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (s_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `CHECK_ALWAYS(a_count_bound, count_reg <= CNT_W'(CAPACITY), "entry count above capacity")
    `CHECK_NEXT(a_count_idle, !s_fire, $stable(count_reg), "count moved without a word")
    `CHECK_NEXT(a_count_step, s_fire,
        (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + CNT_W'(1)) ||
        (count_reg == $past(count_reg) - CNT_W'(1)), "count moved by more than one")
    `CHECK_IMPL(a_found_ok, m_tvalid && m_tdata[BYTE_W],
        m_tdata[BYTE_W + 1 + FIDX_W +: STAT_W] == ST_OK, "found flag with bad status")

endmodule

@@ test/tb.sv @@
// testbench for positional_byte_list_engine_core: directed and random list operations
// with a queue-based list predictor, random idling on both sides and a long receiver stall
// depends on pble_pkg and the rtl under src
`timescale 1ns / 1ps

module tb;
    import pble_pkg::*;

    typedef struct packed {
        mode_t               mode;
        logic [POS_W-1:0]    position;
        logic [BYTE_W-1:0]   data_in;
    } list_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   data_out;
        logic                found;
        logic [FIDX_W-1:0]   found_index;
        status_t             status;
        logic [COUNT_W-1:0]  count;
    } list_result_t;

    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_WORDS  = 150;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;

    list_word_t    pending[$];
    list_result_t  due_results[$];
    logic [BYTE_W-1:0] held[$];

    list_word_t    cur_word;
    list_result_t  want;
    list_result_t  exp_res;
    list_result_t  got;
    int            n_taken = 0;
    int            total_words = 0;
    int            gen_count = 0;
    int            s_gap = 0;
    int            m_gap = 0;
    int            hold_left = 0;
    logic          hold_done = 1'b0;
    logic          quiet_tail;
    int            errors = 0;
    int            n_full = 0, n_empty = 0, n_range = 0, n_found = 0, peak_fill = 0;

    mode_t grow_set[3]   = '{MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_INSERT};
    mode_t shrink_set[3] = '{MODE_POP_FRONT, MODE_POP_BACK, MODE_REMOVE};

    positional_byte_list_engine_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    assign quiet_tail = (n_taken >= total_words - TAIL_WORDS);

    // predictor: applies one word to the held list and returns the result word
    function automatic list_result_t list_apply(list_word_t w);
        list_result_t r;
        int p;
        r = '0;
        r.status = ST_OK;
        p = w.position;
        case (w.mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                if (held.size() >= CAPACITY) r.status = ST_FULL;
                else if (w.mode == MODE_PUSH_FRONT) held = {w.data_in, held};
                else held = {held, w.data_in};
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
                if (held.size() == 0) r.status = ST_EMPTY;
                else if (w.mode == MODE_POP_FRONT) begin
                    r.data_out = held[0];
                    held.delete(0);
                end else begin
                    r.data_out = held[held.size() - 1];
                    held.delete(held.size() - 1);
                end
            end
            MODE_INSERT: begin
                if (held.size() >= CAPACITY) r.status = ST_FULL;
                else if (p > held.size()) r.status = ST_RANGE;
                else held.insert(p, w.data_in);
            end
            MODE_REMOVE: begin
                if (held.size() == 0) r.status = ST_EMPTY;
                else if (p >= held.size()) r.status = ST_RANGE;
                else begin
                    r.data_out = held[p];
                    held.delete(p);
                end
            end
            MODE_READ: begin
                if (p >= held.size()) r.status = ST_RANGE;
                else r.data_out = held[p];
            end
            default: begin
                for (int i = 0; i < held.size() && !r.found; i++) begin
                    if (held[i] == w.data_in) begin
                        r.found = 1'b1;
                        r.found_index = FIDX_W'(i);
                    end
                end
            end
        endcase
        r.count = COUNT_W'(held.size());
        return r;
    endfunction

    // queues a word and tracks the fill level the generator expects
    task automatic add_word(mode_t mode, int pos, int data);
        list_word_t w;
        w.mode = mode;
        w.position = POS_W'(pos);
        w.data_in = BYTE_W'(data);
        pending = {pending, w};
        case (mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: if (gen_count < CAPACITY) gen_count++;
            MODE_INSERT: if (gen_count < CAPACITY && pos <= gen_count) gen_count++;
            MODE_POP_FRONT, MODE_POP_BACK: if (gen_count > 0) gen_count--;
            MODE_REMOVE: if (gen_count > 0 && pos < gen_count) gen_count--;
            default: ;
        endcase
    endtask

    // bias 0 grows the list, 1 drains it, 2 is uniform
    task automatic add_random(int bias);
        mode_t mode;
        int pos;
        int data;
        int sel;
        sel = $urandom_range(0, 99);
        if (bias == 0 && sel < 70) mode = grow_set[$urandom_range(0, 2)];
        else if (bias == 1 && sel < 70) mode = shrink_set[$urandom_range(0, 2)];
        else mode = mode_t'($urandom_range(0, 7));
        sel = $urandom_range(0, 9);
        if (sel == 0) pos = $urandom_range(0, 127);
        else if (sel == 1) pos = gen_count;
        else if (mode == MODE_INSERT) pos = $urandom_range(0, gen_count);
        else pos = (gen_count == 0) ? 0 : $urandom_range(0, gen_count - 1);
        data = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 255);
        add_word(mode, pos, data);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                want = list_apply(cur_word);
                due_results = {due_results, want};
                n_taken <= n_taken + 1;
                if (want.status == ST_FULL) n_full++;
                if (want.status == ST_EMPTY) n_empty++;
                if (want.status == ST_RANGE) n_range++;
                if (want.found) n_found++;
                if (want.count > peak_fill) peak_fill = want.count;
            end
            if (!s_tvalid || s_tready) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending.size() != 0 && !quiet_tail
                             && $urandom_range(0, 15) == 0) begin
                    s_gap = $urandom_range(0, 11);
                    s_tvalid <= 1'b0;
                end else if (pending.size() != 0) begin
                    cur_word = pending[0];
                    pending.delete(0);
                    s_tdata <= {{(S_DATA_W - MODE_W - POS_W - BYTE_W){1'b0}},
                                cur_word.data_in, cur_word.position, cur_word.mode};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver stall once traffic is under way
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && n_taken >= 500) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            m_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.data_out    = m_tdata[7:0];
                got.found       = m_tdata[8];
                got.found_index = m_tdata[14:9];
                got.status      = status_t'(m_tdata[16:15]);
                got.count       = m_tdata[23:17];
                if (due_results.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result word %h at %0t", m_tdata, $realtime);
                end else begin
                    exp_res = due_results[0];
                    due_results.delete(0);
                    if (got !== exp_res) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch at %0t: exp data %0d found %0d idx %0d st %0d",
                                      " cnt %0d / got data %0d found %0d idx %0d st %0d cnt %0d"},
                                     $realtime, exp_res.data_out, exp_res.found,
                                     exp_res.found_index, exp_res.status, exp_res.count,
                                     got.data_out, got.found, got.found_index, got.status,
                                     got.count);
                    end
                end
            end
            if (hold_left != 0) begin
                m_tready <= 1'b0;
            end else if (m_gap > 0) begin
                m_gap--;
                m_tready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
                m_gap = $urandom_range(0, 11);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        // empty list corner cases
        add_word(MODE_POP_FRONT, 0, 8'hFF);
        add_word(MODE_POP_BACK, 127, 8'h00);
        add_word(MODE_REMOVE, 0, 8'h00);
        add_word(MODE_REMOVE, 127, 8'hFF);
        add_word(MODE_READ, 0, 8'h00);
        add_word(MODE_FIND, 0, 8'h00);
        add_word(MODE_INSERT, 1, 8'h11);
        // build a short list and probe it
        add_word(MODE_INSERT, 0, 8'hA5);
        add_word(MODE_PUSH_FRONT, 127, 8'hFF);
        add_word(MODE_PUSH_BACK, 0, 8'h00);
        add_word(MODE_INSERT, 3, 8'h5A);
        add_word(MODE_INSERT, 2, 8'h3C);
        add_word(MODE_READ, 0, 8'h00);
        add_word(MODE_READ, 4, 8'h00);
        add_word(MODE_READ, 5, 8'h00);
        add_word(MODE_READ, 127, 8'h00);
        add_word(MODE_FIND, 0, 8'h3C);
        add_word(MODE_FIND, 127, 8'h77);
        add_word(MODE_REMOVE, 2, 8'h00);
        add_word(MODE_REMOVE, 4, 8'h00);
        add_word(MODE_INSERT, 6, 8'h22);
        add_word(MODE_POP_FRONT, 0, 8'h00);
        add_word(MODE_POP_BACK, 0, 8'h00);
        // fill past capacity, drain past empty, then mixed segments
        repeat (90) add_random(0);
        repeat (90) add_random(1);
        while (pending.size() < 1400) begin
            int bias;
            int seg_len;
            bias = $urandom_range(0, 2);
            seg_len = $urandom_range(30, 100);
            repeat (seg_len) add_random(bias);
        end
        total_words = pending.size();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        do @(posedge aclk);
        while (pending.size() != 0 || s_tvalid || due_results.size() != 0);
        repeat (10) @(posedge aclk);
        errors += due_results.size();

        $display("%0d words: %0d full, %0d empty, %0d out of range, %0d finds hit, peak fill %0d",
                 n_taken, n_full, n_empty, n_range, n_found, peak_fill);
        $display("idle bursts on both sides, one %0d-cycle receiver stall, %0d errors",
                 HOLD_CYCLES, errors);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout waiting for results");
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/pble_pkg.sv
src/pble_cell.sv
src/pble_pick.sv
src/positional_byte_list_engine_core.sv
test/tb.sv
